[hdl/lsfd_pkg.sv]
// Shared types and constants for the LSB steganography frame decoder.
package lsfd_pkg;

	// Bits in a length word and the most magic bytes checked.
	localparam int LENGTH_BITS     = 32;
	localparam int MAGIC_MAX_BYTES = 8;

	// Reset values of the configuration registers.
	localparam logic [7:0]  HEADER_SKIP_RST = 8'd54;
	localparam logic [3:0]  MAGIC_LEN_RST   = 4'd2;
	localparam logic [63:0] MAGIC_VALUE_RST = 64'd0;

	// Configuration register indexes.
	localparam logic [1:0] CFG_HEADER_SKIP = 2'd0;
	localparam logic [1:0] CFG_MAGIC_LEN   = 2'd1;
	localparam logic [1:0] CFG_MAGIC_VALUE = 2'd2;

	// Field kinds of a result beat.
	localparam logic [2:0] KIND_MAGIC   = 3'd0;
	localparam logic [2:0] KIND_EXTLEN  = 3'd1;
	localparam logic [2:0] KIND_EXTBYTE = 3'd2;
	localparam logic [2:0] KIND_DATALEN = 3'd3;
	localparam logic [2:0] KIND_DATA    = 3'd4;

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_MAGIC,
		PH_EXTLEN,
		PH_EXTBYTES,
		PH_DATALEN,
		PH_DATABYTES,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic       start_of_image;
	} img_beat_t;

	typedef struct packed {
		logic [2:0]  field_kind;
		logic [31:0] field_value;
		logic        magic_ok;
		logic        last_of_payload;
	} fld_beat_t;

	typedef struct packed {
		logic [7:0]  header_skip;
		logic [3:0]  magic_len;
		logic [63:0] magic_value;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  header_left;
		logic [4:0]  bit_position;
		logic [31:0] assembly;
		logic [31:0] remaining;
		logic [2:0]  magic_index;
		logic        magic_good;
	} parse_state_t;

endpackage

[hdl/lsfd_step.sv]
// Next-state and result logic of the frame parser for one image byte.
module lsfd_step (
	input  lsfd_pkg::parse_state_t cur,
	input  lsfd_pkg::cfg_t         cfg,
	input  lsfd_pkg::img_beat_t    beat,
	output lsfd_pkg::parse_state_t nxt,
	output logic                   emit,
	output lsfd_pkg::fld_beat_t    res
);

	logic [3:0]  eff_magic_len;
	logic [4:0]  need_m1;
	logic [31:0] asm_word;
	logic [7:0]  want;
	logic [31:0] rem_dec;
	logic        active;
	logic        good;
	lsfd_pkg::parse_state_t w;

	// Magic lengths beyond the supported count are clamped.
	assign eff_magic_len = (cfg.magic_len > 4'(lsfd_pkg::MAGIC_MAX_BYTES)) ?
		4'(lsfd_pkg::MAGIC_MAX_BYTES) : cfg.magic_len;

	always_comb begin
		w      = cur;
		active = 1'b1;
		emit   = 1'b0;
		res    = '0;

		// Start of image restarts the parse on this same byte.
		if (beat.start_of_image) begin
			w.phase        = lsfd_pkg::PH_SKIP;
			w.header_left  = cfg.header_skip;
			w.bit_position = '0;
			w.assembly     = '0;
			w.remaining    = '0;
			w.magic_index  = '0;
			w.magic_good   = 1'b1;
		end

		// Header skip: count down, then open the first field.
		if (w.phase == lsfd_pkg::PH_SKIP) begin
			if (w.header_left != 8'd0) begin
				w.header_left = w.header_left - 8'd1;
				active        = 1'b0;
			end else begin
				w.phase        = (eff_magic_len != 4'd0) ? lsfd_pkg::PH_MAGIC :
					lsfd_pkg::PH_EXTLEN;
				w.bit_position = '0;
				w.assembly     = '0;
				w.magic_index  = '0;
			end
		end
		if (w.phase == lsfd_pkg::PH_DONE) begin
			active = 1'b0;
		end

		// Gather one hidden bit, LSB first.
		need_m1  = (w.phase == lsfd_pkg::PH_EXTLEN || w.phase == lsfd_pkg::PH_DATALEN) ?
			5'(lsfd_pkg::LENGTH_BITS - 1) : 5'd7;
		asm_word = w.assembly | (32'(beat.pixel_byte[0]) << w.bit_position);
		want     = cfg.magic_value[8 * w.magic_index +: 8];
		rem_dec  = w.remaining - 32'd1;
		good     = w.magic_good & (asm_word == {24'd0, want});

		if (active) begin
			if (w.bit_position != need_m1) begin
				w.bit_position = w.bit_position + 5'd1;
				w.assembly     = asm_word;
			end else begin
				emit              = 1'b1;
				res.field_value   = asm_word;
				w.bit_position    = '0;
				w.assembly        = '0;
				unique case (w.phase)
					lsfd_pkg::PH_MAGIC: begin
						res.field_kind = lsfd_pkg::KIND_MAGIC;
						res.magic_ok   = good;
						w.magic_good   = good;
						if ({1'b0, w.magic_index} + 4'd1 >= eff_magic_len) begin
							w.phase = lsfd_pkg::PH_EXTLEN;
						end else begin
							w.magic_index = w.magic_index + 3'd1;
						end
					end
					lsfd_pkg::PH_EXTLEN: begin
						res.field_kind = lsfd_pkg::KIND_EXTLEN;
						w.remaining    = asm_word;
						w.phase        = (asm_word != 32'd0) ? lsfd_pkg::PH_EXTBYTES :
							lsfd_pkg::PH_DATALEN;
					end
					lsfd_pkg::PH_EXTBYTES: begin
						res.field_kind = lsfd_pkg::KIND_EXTBYTE;
						w.remaining    = rem_dec;
						w.phase        = (rem_dec != 32'd0) ? lsfd_pkg::PH_EXTBYTES :
							lsfd_pkg::PH_DATALEN;
					end
					lsfd_pkg::PH_DATALEN: begin
						res.field_kind      = lsfd_pkg::KIND_DATALEN;
						res.last_of_payload = (asm_word == 32'd0);
						w.remaining         = asm_word;
						w.phase             = (asm_word != 32'd0) ? lsfd_pkg::PH_DATABYTES :
							lsfd_pkg::PH_DONE;
					end
					default: begin
						res.field_kind      = lsfd_pkg::KIND_DATA;
						res.last_of_payload = (w.remaining == 32'd1);
						w.remaining         = rem_dec;
						w.phase             = (rem_dec != 32'd0) ? lsfd_pkg::PH_DATABYTES :
							lsfd_pkg::PH_DONE;
					end
				endcase
			end
		end
		nxt = w;
	end

endmodule

[hdl/lsb_stego_frame_decoder.sv]
// Top level of the LSB steganography frame decoder: registers, handshakes, checks.
//
// Usage:
//   img channel (img_valid / img_stall / img_beat): one image byte per beat;
//   start_of_image marks byte 0 of an image and restarts the parse on it.
//   fld channel (fld_valid / fld_stall / fld_beat): one beat per completed
//   magic byte, extension length, extension byte, data length or data byte.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//   writes, always ready; write only while the decoder is idle.
// Throughput: one image byte per cycle while fld_stall holds no result. The
//   parser state updates in one pass of logic between the input stage register
//   and the result register, which registers the field that a byte completes.
// Reset: header skip 54, magic length 2, magic value 0; the parser waits in
//   header skip, so bytes before the first start count as a new image.
// Stall: while fld_stall holds a result, the input stage holds its byte and
//   img_stall rises; no beat is lost or repeated.
module lsb_stego_frame_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                img_valid,
	output logic                img_stall,
	input  lsfd_pkg::img_beat_t img_beat,
	output logic                fld_valid,
	input  logic                fld_stall,
	output lsfd_pkg::fld_beat_t fld_beat,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_data
);

	lsfd_pkg::img_beat_t    beat_s1;
	logic                   valid_s1;
	lsfd_pkg::parse_state_t state_q;
	lsfd_pkg::parse_state_t state_nxt;
	lsfd_pkg::cfg_t         cfg_q;
	lsfd_pkg::fld_beat_t    res;
	lsfd_pkg::fld_beat_t    out_q;
	logic                   out_valid_q;
	logic                   emit;
	logic                   advance;

	// Input stage moves on whenever the result register is free or drains.
	assign advance   = valid_s1 & (~out_valid_q | ~fld_stall);
	assign img_stall = valid_s1 & ~advance;
	assign cfg_ready = 1'b1;
	assign fld_valid = out_valid_q;
	assign fld_beat  = out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_skip <= lsfd_pkg::HEADER_SKIP_RST;
			cfg_q.magic_len   <= lsfd_pkg::MAGIC_LEN_RST;
			cfg_q.magic_value <= lsfd_pkg::MAGIC_VALUE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lsfd_pkg::CFG_HEADER_SKIP: cfg_q.header_skip <= cfg_data[7:0];
				lsfd_pkg::CFG_MAGIC_LEN:   cfg_q.magic_len   <= cfg_data[3:0];
				lsfd_pkg::CFG_MAGIC_VALUE: cfg_q.magic_value <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!img_stall) begin
			valid_s1 <= img_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (img_valid && !img_stall) begin
			beat_s1 <= img_beat;
		end
	end

	lsfd_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.beat (beat_s1),
		.nxt  (state_nxt),
		.emit (emit),
		.res  (res)
	);

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= lsfd_pkg::PH_SKIP;
			state_q.header_left  <= lsfd_pkg::HEADER_SKIP_RST;
			state_q.bit_position <= '0;
			state_q.assembly     <= '0;
			state_q.remaining    <= '0;
			state_q.magic_index  <= '0;
			state_q.magic_good   <= 1'b1;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !fld_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

`ifndef NO_ASSERTIONS
	// Backpressure only while a byte sits in the input stage.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		img_stall |-> valid_s1)
		else $error("img_stall without a byte in the input stage");

	// A held result freezes the parser.
	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(fld_valid && fld_stall) |=> $stable(state_q))
		else $error("parser state moved while result was stalled");

	// Magic flag only on magic bytes.
	a_magic_ok_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(fld_valid && fld_beat.field_kind != lsfd_pkg::KIND_MAGIC) |-> !fld_beat.magic_ok)
		else $error("magic_ok set on a non-magic field");

	// Last marker only on data length or data bytes.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(fld_valid && fld_beat.last_of_payload) |->
		(fld_beat.field_kind == lsfd_pkg::KIND_DATALEN ||
		 fld_beat.field_kind == lsfd_pkg::KIND_DATA))
		else $error("last_of_payload on a field that cannot end the payload");
`endif

endmodule
